### design/mpss_pkg.sv
// Shared types and codes for the multi-pattern stream scanner.
// Used by the cell, the top level and port payloads; no dependencies.
package mpss_pkg;

  // Request type codes
  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_WR_BYTE = 2'd1;
  localparam logic [1:0] REQ_WR_LEN  = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // Register indexes (word address bits [3:2])
  localparam logic [1:0] REG_BYTE_MASK  = 2'd0;
  localparam logic [1:0] REG_SCAN_FIRST = 2'd1;
  localparam logic [1:0] REG_SCAN_LAST  = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] pattern_index;
    logic [4:0] position;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [15:0] complete_mask;
    logic [15:0] new_mask;
    logic [15:0] seen_flags;
    logic        progressed;
  } rsp_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic       scan;      // data byte under compare
    logic       retry;     // compare against the position-0 byte
    logic       commit;    // item finishes this cycle
    logic       clr_prog;  // clear progress
    logic       clr_seen;  // clear seen flag
    logic       wr_byte;   // pattern byte write, position in range
    logic       wr_len;    // pattern length write
    logic [3:0] idx;
    logic [4:0] pos;
    logic [7:0] value;
    logic [7:0] cbyte;     // masked data byte
    logic [7:0] mask;
  } cell_ctrl_t;

endpackage

### design/mpss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mpss_cell.sv
// One pattern slot: pattern RAM, length, progress and seen flag.
// Depends on mpss_pkg and mpss_ram; chained through the hit signal.
module mpss_cell #(
  parameter int PATTERN_LEN = 32,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mpss_pkg::cell_ctrl_t               ctrl,
  input  logic                               en,
  input  logic [$clog2(PATTERN_LEN+1)-1:0]   pos_s,
  input  logic                               hit_in,
  output logic                               hit_out,
  output logic                               done,
  output logic                               fresh,
  output logic                               seen
);
  import mpss_pkg::*;

  localparam int AW = $clog2(PATTERN_LEN);
  localparam int LW = $clog2(PATTERN_LEN + 1);

  logic [LW-1:0] prog;
  logic [LW-1:0] len;
  logic [LW-1:0] prog_inc;
  logic          seen_q;
  logic [7:0]    byte0;
  logic [7:0]    rdata;
  logic [7:0]    pbyte;
  logic          sel;
  logic          part;
  logic          hit;

  assign sel = (32'(ctrl.idx) == INDEX);

  // Pattern bytes, read at the shared position
  mpss_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_byte && sel),
    .waddr (AW'(ctrl.pos)),
    .wdata (ctrl.value),
    .raddr (AW'(pos_s)),
    .rdata (rdata)
  );

  // Copy of the first byte for the retry pass
  always_ff @(posedge clk) begin
    if (ctrl.wr_byte && sel && (ctrl.pos == '0)) begin
      byte0 <= ctrl.value;
    end
  end

  // Compare
  assign part     = en && (prog == pos_s) && (prog < len);
  assign pbyte    = ctrl.retry ? byte0 : rdata;
  assign hit      = ctrl.scan && part && ((pbyte & ctrl.mask) == ctrl.cbyte);
  assign prog_inc = prog + 1'b1;
  assign done     = hit && (prog_inc == len);
  assign fresh    = done && !seen_q;
  assign hit_out  = hit_in | hit;
  assign seen     = seen_q;

  // Progress, length and seen flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prog   <= '0;
      len    <= '0;
      seen_q <= 1'b0;
    end else begin
      if (ctrl.clr_prog) begin
        prog <= '0;
      end else if (ctrl.commit && hit) begin
        prog <= prog_inc;
      end
      if (ctrl.clr_seen) begin
        seen_q <= 1'b0;
      end else if (ctrl.commit && fresh) begin
        seen_q <= 1'b1;
      end
      if (ctrl.wr_len && sel) begin
        len <= (ctrl.value > 8'(PATTERN_LEN)) ? LW'(PATTERN_LEN) : LW'(ctrl.value);
      end
    end
  end

endmodule

### design/multi_pattern_stream_scanner.sv
// Multi-pattern stream scanner: sequencer, config registers, cell chain.
// Depends on mpss_pkg, mpss_cell and mpss_ram.
//
// The accept edge presents the shared position to every cell's pattern RAM,
// and the next cycle compares the masked data byte in all enabled cells at
// once; the result register is written once it is free. A data byte that
// misses every pattern at a nonzero position takes a retry pass: the
// progress counts clear and the byte is compared again against each cell's
// copy of its first pattern byte. Writes and clears never take a retry pass.
// One item is in work at a time; an item is accepted while its predecessor's
// result still waits in the output register, but it finishes only once that
// register is free. Configuration must be written through the APB port only
// while the block is idle; the block does not enforce it. All registers read back.
module multi_pattern_stream_scanner #(
  parameter int NUM_PATTERNS = 16,
  parameter int PATTERN_LEN  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  mpss_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output mpss_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpss_pkg::ADDR_W-1:0] paddr,
  input  logic [mpss_pkg::DATA_W-1:0] pwdata,
  output logic [mpss_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mpss_pkg::*;

  localparam int LW = $clog2(PATTERN_LEN + 1);
  localparam int MB = (NUM_PATTERNS < 16) ? NUM_PATTERNS : 16;

  typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_RETRY} state_t;

  state_t            state;
  req_t              req_q;
  logic [LW-1:0]     pos_s;
  logic [7:0]        byte_mask;
  logic [3:0]        scan_first;
  logic [3:0]        scan_last;
  cell_ctrl_t        ctrl;
  logic [7:0]        cbyte;
  logic              scan;
  logic              any_hit;
  logic              out_free;
  logic              go_retry;
  logic              commit;
  logic [NUM_PATTERNS-1:0] en;
  logic [NUM_PATTERNS-1:0] done_v;
  logic [NUM_PATTERNS-1:0] fresh_v;
  logic [NUM_PATTERNS-1:0] seen_v;
  logic [NUM_PATTERNS:0]   hit_chain;
  logic [15:0]       done16;
  logic [15:0]       fresh16;
  logic [15:0]       seen16;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mask  <= 8'hFF;
      scan_first <= 4'd0;
      scan_last  <= 4'd15;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BYTE_MASK:  byte_mask  <= pwdata[7:0];
        REG_SCAN_FIRST: scan_first <= pwdata[3:0];
        REG_SCAN_LAST:  scan_last  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BYTE_MASK:  prdata = DATA_W'(byte_mask);
      REG_SCAN_FIRST: prdata = DATA_W'(scan_first);
      REG_SCAN_LAST:  prdata = DATA_W'(scan_last);
      default:        prdata = '0;
    endcase
  end

  // Sequencer decisions
  assign req_ready = (state == ST_IDLE);
  assign cbyte     = req_q.value & byte_mask;
  assign scan      = (state != ST_IDLE) && (req_q.req_type == REQ_DATA) && (cbyte != 8'd0);
  assign any_hit   = hit_chain[NUM_PATTERNS];
  assign out_free  = !rsp_valid || rsp_ready;
  assign go_retry  = (state == ST_PASS) && scan && !any_hit && (pos_s != '0);
  assign commit    = (((state == ST_PASS) && !go_retry) || (state == ST_RETRY)) && out_free;

  always_comb begin
    ctrl.scan     = scan;
    ctrl.retry    = (state == ST_RETRY);
    ctrl.commit   = commit;
    ctrl.clr_prog = go_retry || (commit && (req_q.req_type == REQ_CLEAR));
    ctrl.clr_seen = commit && (req_q.req_type == REQ_CLEAR);
    ctrl.wr_byte  = commit && (req_q.req_type == REQ_WR_BYTE)
                    && (32'(req_q.position) < PATTERN_LEN);
    ctrl.wr_len   = commit && (req_q.req_type == REQ_WR_LEN);
    ctrl.idx      = req_q.pattern_index;
    ctrl.pos      = req_q.position;
    ctrl.value    = req_q.value;
    ctrl.cbyte    = cbyte;
    ctrl.mask     = byte_mask;
  end

  // Cell chain
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
    assign en[i] = (32'(scan_first) <= i) && (32'(scan_last) >= i);

    mpss_cell #(
      .PATTERN_LEN (PATTERN_LEN),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .en      (en[i]),
      .pos_s   (pos_s),
      .hit_in  (hit_chain[i]),
      .hit_out (hit_chain[i+1]),
      .done    (done_v[i]),
      .fresh   (fresh_v[i]),
      .seen    (seen_v[i])
    );
  end

  assign done16  = 16'(done_v[MB-1:0]);
  assign fresh16 = 16'(fresh_v[MB-1:0]);
  assign seen16  = 16'(seen_v[MB-1:0]);

  // Request capture
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // State, shared position and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      pos_s     <= '0;
    end else begin
      // a new result in the same cycle keeps valid high
      if (rsp_valid && rsp_ready && !commit) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_PASS;
          end
        end
        ST_PASS, ST_RETRY: begin
          if (go_retry) begin
            pos_s <= '0;
            state <= ST_RETRY;
          end else if (commit) begin
            state             <= ST_IDLE;
            rsp_valid         <= 1'b1;
            rsp.complete_mask <= done16;
            rsp.new_mask      <= fresh16;
            rsp.seen_flags    <= (req_q.req_type == REQ_CLEAR) ? 16'd0 : (seen16 | fresh16);
            rsp.progressed    <= scan && any_hit;
            if (req_q.req_type == REQ_CLEAR) begin
              pos_s <= '0;
            end else if (scan && any_hit) begin
              pos_s <= pos_s + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The retry pass always runs from position zero
  a_retry_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RETRY) |-> (pos_s == '0))
    else $error("retry pass with nonzero shared position");

  // A newly seen pattern is one that completed on this byte
  a_new_in_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.new_mask & ~rsp.complete_mask) == 16'd0))
    else $error("new_mask bit without completion");

  // Nothing completes without progress
  a_done_progress: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.progressed) |-> (rsp.complete_mask == 16'd0))
    else $error("completion reported without progress");

  // A byte that advanced moves the shared position by one
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (commit && scan && any_hit) |=> (pos_s == LW'($past(pos_s) + 1'b1)))
    else $error("shared position did not advance");
`endif

endmodule
